/* src/trs_pkg.sv */
// ----------------------------------------------------------------------------
// TLV record scanner package
// Shared item types, scan state type and format constants.
// ----------------------------------------------------------------------------
package trs_pkg;

    localparam int BUFFER_BYTES_DEF = 512;
    localparam int MAX_RECORDS_DEF  = 40;

    localparam logic [7:0] STRING_FLAG     = 8'h80;
    localparam logic [7:0] TYPE_LIMIT      = 8'd10;
    localparam logic [7:0] NUMERIC_MAX_LEN = 8'd4;
    localparam logic [8:0] HEADER_BYTES    = 9'd2;
    localparam logic [7:0] PRINT_LOW       = 8'h20;
    localparam logic [7:0] PRINT_HIGH      = 8'h7E;
    localparam logic [5:0] LIMIT_RESET     = 6'd40;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_buffer;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  record_tag;
        logic [7:0]  record_length;
        logic [31:0] numeric_value;
        logic [8:0]  string_offset;
        logic        record_valid;
        logic        last_record;
    } t_out_item;

    typedef enum logic [3:0] {
        S_IDLE,
        S_HEAD,
        S_TYPE,
        S_LEN,
        S_STR_FIRST,
        S_STR_LAST,
        S_NUM,
        S_EMIT,
        S_FLUSH
    } t_scan_state;

endpackage

/* src/tlv_record_scanner_unit.sv */
// ----------------------------------------------------------------------------
// TLV record scanner unit
// Loads a byte buffer, then scans it for type-length-value records.
// ----------------------------------------------------------------------------
// Usage: bytes arrive on the input channel (i_valid / o_stall), one transfer
// per byte, at one byte per cycle into the byte store while o_stall is low.
// The transfer whose end_of_buffer bit is set closes the buffer and starts
// the scan; o_stall stays high from the cycle after that transfer until the
// scan has finished, since the scanner reads the same store.
// Results leave on the output channel (o_valid / i_stall). Each found record
// is one transfer; the final transfer of a scan carries last_record, and an
// empty scan gives a single transfer with record_valid low.
// Scanning: the scanner reads one stored byte per cycle. A candidate
// record is checked by reading its type byte and its length byte, then
// the first and last bytes of a string or each numeric byte in turn.
// The output register and a one-record holding register decouple the two
// channels: a stalled receiver halts the scanner when both are full, and
// holds the close of a scan while the output register is full.
// Reset (synchronous, active low) empties the buffer, drops any scan in
// progress and any pending result, and sets the record limit to 40.
// The user must write the record limit (i_cfg_wr_en / i_cfg_wr_data) only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module tlv_record_scanner_unit #(
    parameter int BUFFER_BYTES = trs_pkg::BUFFER_BYTES_DEF,
    parameter int MAX_RECORDS  = trs_pkg::MAX_RECORDS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  trs_pkg::t_in_item  i_data,
    output logic               o_valid,
    input  logic               i_stall,
    output trs_pkg::t_out_item o_data,
    input  logic               i_cfg_wr_en,
    input  logic [5:0]         i_cfg_wr_data
);
    import trs_pkg::*;

    localparam int CW = $clog2(BUFFER_BYTES + 1);
    localparam int AW = $clog2(BUFFER_BYTES);

    // Store write port and the scan command handed from front to back.
    logic          w_wr_en;
    logic [AW-1:0] w_wr_addr;
    logic [7:0]    w_wr_data;
    logic          w_cmd_valid;
    logic [CW-1:0] w_cmd_count;
    logic [5:0]    w_cmd_limit;
    logic          w_cmd_take;
    logic          w_back_busy;

    trs_front #(
        .BUFFER_BYTES (BUFFER_BYTES),
        .MAX_RECORDS  (MAX_RECORDS),
        .CW           (CW),
        .AW           (AW)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_data        (i_data),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_back_busy   (w_back_busy),
        .o_wr_en       (w_wr_en),
        .o_wr_addr     (w_wr_addr),
        .o_wr_data     (w_wr_data),
        .o_cmd_valid   (w_cmd_valid),
        .o_cmd_count   (w_cmd_count),
        .o_cmd_limit   (w_cmd_limit),
        .i_cmd_take    (w_cmd_take)
    );

    // The scanner owns the byte store and the output register.
    trs_back #(
        .BUFFER_BYTES (BUFFER_BYTES),
        .MAX_RECORDS  (MAX_RECORDS),
        .CW           (CW),
        .AW           (AW)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wr_en     (w_wr_en),
        .i_wr_addr   (w_wr_addr),
        .i_wr_data   (w_wr_data),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd_count (w_cmd_count),
        .i_cmd_limit (w_cmd_limit),
        .o_cmd_take  (w_cmd_take),
        .o_busy      (w_back_busy),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_data      (o_data)
    );

endmodule

/* src/trs_front.sv */
// ----------------------------------------------------------------------------
// TLV record scanner front end
// Takes buffer bytes, writes them to the byte store and posts a scan command.
// ----------------------------------------------------------------------------
module trs_front #(
    parameter int BUFFER_BYTES = trs_pkg::BUFFER_BYTES_DEF,
    parameter int MAX_RECORDS  = trs_pkg::MAX_RECORDS_DEF,
    parameter int CW           = $clog2(BUFFER_BYTES + 1),
    parameter int AW           = $clog2(BUFFER_BYTES)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  trs_pkg::t_in_item i_data,
    input  logic              i_cfg_wr_en,
    input  logic [5:0]        i_cfg_wr_data,
    input  logic              i_back_busy,
    output logic              o_wr_en,
    output logic [AW-1:0]     o_wr_addr,
    output logic [7:0]        o_wr_data,
    output logic              o_cmd_valid,
    output logic [CW-1:0]     o_cmd_count,
    output logic [5:0]        o_cmd_limit,
    input  logic              i_cmd_take
);
    import trs_pkg::*;

    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic [5:0]    r_limit;
    logic          r_cmd_valid;
    logic [CW-1:0] r_cmd_count;
    logic [5:0]    r_cmd_limit;
    logic          w_accept;
    logic          w_room;

    // The store is shared with the scanner, so loading waits for the scan.
    assign o_stall  = r_cmd_valid || i_back_busy;
    assign w_accept = i_valid && !o_stall;
    assign w_room   = r_count < CW'(BUFFER_BYTES);

    assign o_wr_en   = w_accept && w_room;
    assign o_wr_addr = r_count[AW-1:0];
    assign o_wr_data = i_data.data_byte;
    assign n_count   = w_room ? r_count + CW'(1) : r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_limit     <= LIMIT_RESET;
            r_cmd_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_limit <= i_cfg_wr_data;
            end
            if (w_accept) begin
                if (i_data.end_of_buffer) begin
                    r_count     <= '0;
                    r_cmd_valid <= 1'b1;
                end else begin
                    r_count <= n_count;
                end
            end else if (i_cmd_take) begin
                r_cmd_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && i_data.end_of_buffer) begin
            r_cmd_count <= n_count;
            r_cmd_limit <= (7'(r_limit) > 7'(MAX_RECORDS)) ? 6'(MAX_RECORDS) : r_limit;
        end
    end

    assign o_cmd_valid = r_cmd_valid;
    assign o_cmd_count = r_cmd_count;
    assign o_cmd_limit = r_cmd_limit;

endmodule

/* src/trs_back.sv */
// ----------------------------------------------------------------------------
// TLV record scanner back end
// Holds the byte store and walks it for records, one byte read per cycle.
// ----------------------------------------------------------------------------
module trs_back #(
    parameter int BUFFER_BYTES = trs_pkg::BUFFER_BYTES_DEF,
    parameter int MAX_RECORDS  = trs_pkg::MAX_RECORDS_DEF,
    parameter int CW           = $clog2(BUFFER_BYTES + 1),
    parameter int AW           = $clog2(BUFFER_BYTES)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_wr_en,
    input  logic [AW-1:0]      i_wr_addr,
    input  logic [7:0]         i_wr_data,
    input  logic               i_cmd_valid,
    input  logic [CW-1:0]      i_cmd_count,
    input  logic [5:0]         i_cmd_limit,
    output logic               o_cmd_take,
    output logic               o_busy,
    output logic               o_valid,
    input  logic               i_stall,
    output trs_pkg::t_out_item o_data
);
    import trs_pkg::*;

    localparam int FW = $clog2(MAX_RECORDS + 1);
    localparam int SW = ((CW > 9) ? CW : 9) + 1;

    logic [7:0]    mem [BUFFER_BYTES];
    logic [7:0]    r_rd_data;
    logic [AW-1:0] w_rd_addr;
    logic [8:0]    w_rd_off;
    logic [SW-1:0] w_rd_sum;

    t_scan_state r_state;
    t_scan_state n_state;

    logic [CW-1:0] r_count;
    logic [5:0]    r_limit;
    logic [CW-1:0] r_pos;
    logic [FW-1:0] r_found;
    logic [7:0]    r_type;
    logic [7:0]    r_len;
    logic [7:0]    r_tag;
    logic [31:0]   r_value;
    logic [1:0]    r_idx;
    logic          r_pend_valid;
    t_out_item     r_pend;
    logic          r_out_valid;
    t_out_item     r_out;

    logic [CW-1:0] w_rem;
    logic          w_more;
    logic          w_type_ok;
    logic          w_fits;
    logic          w_is_str;
    logic          w_printable;
    logic          w_out_free;
    logic [CW-1:0] w_next_pos;
    logic [31:0]   w_byte_sh;
    t_out_item     w_rec;
    t_out_item     w_final;

    // Byte store: written by the front end, read every cycle by the scanner.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= mem[w_rd_addr];
    end

    assign w_rd_sum  = SW'(r_pos) + SW'(w_rd_off);
    assign w_rd_addr = w_rd_sum[AW-1:0];

    assign w_rem       = r_count - r_pos;
    assign w_more      = (r_pos < r_count) && (7'(r_found) < 7'(r_limit));
    assign w_type_ok   = ((r_rd_data != 8'd0) && (r_rd_data < TYPE_LIMIT))
                         || (r_rd_data == STRING_FLAG);
    assign w_fits      = SW'(w_rem) >= (SW'(HEADER_BYTES) + SW'(r_rd_data));
    assign w_is_str    = (r_type == STRING_FLAG) || (r_rd_data > NUMERIC_MAX_LEN);
    assign w_printable = (r_rd_data >= PRINT_LOW) && (r_rd_data <= PRINT_HIGH);
    assign w_out_free  = !r_out_valid || !i_stall;
    assign w_next_pos  = CW'(SW'(r_pos) + SW'(HEADER_BYTES) + SW'(r_len));

    always_comb begin
        unique case (r_idx)
            2'd0:    w_byte_sh = {24'd0, r_rd_data};
            2'd1:    w_byte_sh = {16'd0, r_rd_data, 8'd0};
            2'd2:    w_byte_sh = {8'd0, r_rd_data, 16'd0};
            default: w_byte_sh = {r_rd_data, 24'd0};
        endcase
    end

    always_comb begin
        w_rec.record_tag    = r_tag;
        w_rec.record_length = r_len;
        w_rec.record_valid  = 1'b1;
        w_rec.last_record   = 1'b0;
        if (r_tag[7]) begin
            w_rec.numeric_value = '0;
            w_rec.string_offset = 9'(SW'(r_pos) + SW'(HEADER_BYTES));
        end else begin
            w_rec.numeric_value = r_value;
            w_rec.string_offset = '0;
        end
        if (r_pend_valid) begin
            w_final             = r_pend;
            w_final.last_record = 1'b1;
        end else begin
            w_final             = '0;
            w_final.last_record = 1'b1;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) n_state = S_HEAD;
            end
            S_HEAD: begin
                if (!w_more) n_state = S_FLUSH;
                else if (w_rem > CW'(2)) n_state = S_TYPE;
            end
            S_TYPE: begin
                n_state = w_type_ok ? S_LEN : S_HEAD;
            end
            S_LEN: begin
                if (!w_fits) n_state = S_HEAD;
                else if (w_is_str) n_state = S_STR_FIRST;
                else if (r_rd_data == 8'd0) n_state = S_EMIT;
                else n_state = S_NUM;
            end
            S_STR_FIRST: begin
                if (!w_printable) n_state = S_HEAD;
                else if (r_len == 8'd0) n_state = S_EMIT;
                else n_state = S_STR_LAST;
            end
            S_STR_LAST: begin
                n_state = (r_rd_data == 8'd0) ? S_EMIT : S_HEAD;
            end
            S_NUM: begin
                if (8'(r_idx) + 8'd1 == r_len) n_state = S_EMIT;
            end
            S_EMIT: begin
                if (!r_pend_valid || w_out_free) n_state = S_HEAD;
            end
            S_FLUSH: begin
                if (w_out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Read offset from the candidate start, per state.
    always_comb begin
        w_rd_off = '0;
        unique case (r_state)
            S_HEAD:      w_rd_off = 9'd0;
            S_TYPE:      w_rd_off = 9'd1;
            S_LEN:       w_rd_off = 9'd2;
            S_STR_FIRST: w_rd_off = 9'd1 + 9'(r_len);
            S_NUM:       w_rd_off = 9'd3 + 9'(r_idx);
            default:     w_rd_off = 9'd0;
        endcase
    end

    assign o_cmd_take = (r_state == S_IDLE);
    assign o_busy     = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_EMIT && (!r_pend_valid || w_out_free)) begin
                r_pend_valid <= 1'b1;
                if (r_pend_valid) begin
                    r_out_valid <= 1'b1;
                end else if (r_out_valid && !i_stall) begin
                    r_out_valid <= 1'b0;
                end
            end else if (r_state == S_FLUSH && w_out_free) begin
                r_pend_valid <= 1'b0;
                r_out_valid  <= 1'b1;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Scan datapath.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_count <= i_cmd_count;
                r_limit <= i_cmd_limit;
                r_pos   <= '0;
                r_found <= '0;
            end
            S_HEAD: begin
                if (w_more && w_rem <= CW'(2)) begin
                    r_pos <= r_pos + CW'(1);
                end
            end
            S_TYPE: begin
                r_type <= r_rd_data;
                if (!w_type_ok) r_pos <= r_pos + CW'(1);
            end
            S_LEN: begin
                r_len   <= r_rd_data;
                r_tag   <= r_type | ((r_rd_data > NUMERIC_MAX_LEN) ? STRING_FLAG : 8'd0);
                r_value <= '0;
                r_idx   <= '0;
                if (!w_fits) r_pos <= r_pos + CW'(1);
            end
            S_STR_FIRST: begin
                if (!w_printable) r_pos <= r_pos + CW'(1);
            end
            S_STR_LAST: begin
                if (r_rd_data != 8'd0) r_pos <= r_pos + CW'(1);
            end
            S_NUM: begin
                r_value <= r_value | w_byte_sh;
                r_idx   <= r_idx + 2'd1;
            end
            S_EMIT: begin
                if (!r_pend_valid || w_out_free) begin
                    if (r_pend_valid) r_out <= r_pend;
                    r_pend  <= w_rec;
                    r_pos   <= w_next_pos;
                    r_found <= r_found + FW'(1);
                end
            end
            S_FLUSH: begin
                if (w_out_free) r_out <= w_final;
            end
            default: begin
            end
        endcase
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

/* bench/tlv_record_scanner_unit_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// TLV record scanner unit testbench
// Loads byte buffers of well-formed, broken and random records into the
// scanner and checks every record it emits against an in-bench prediction
// of the scan, over several record limits and handshake idling patterns.
// ----------------------------------------------------------------------------

import trs_pkg::*;

// Keeps a copy of the buffer being loaded and the record limit, predicts the
// records of each scan and checks the emitted records in order.
class tlv_scoreboard;
    logic [7:0]  buf_bytes [BUFFER_BYTES_DEF];
    int unsigned fill;
    logic [5:0]  rec_limit;
    t_out_item   expected [$];
    int unsigned errors;

    function new();
        fill      = 0;
        rec_limit = LIMIT_RESET;
        errors    = 0;
    endfunction

    function void set_limit(logic [5:0] value);
        rec_limit = value;
    endfunction

    function int unsigned pending_count();
        return expected.size();
    endfunction

    task report(string what);
        $display("mismatch: %s", what);
        errors++;
    endtask

    // Returns the size of the record at pos, or zero when the start is rejected.
    function int unsigned try_record(int unsigned pos, output t_out_item rec);
        int unsigned rem;
        int unsigned size;
        int unsigned last;
        logic [7:0]  kind;
        logic [7:0]  len;
        logic [31:0] value;
        rec = '0;
        rem = fill - pos;
        if (rem <= 2) return 0;
        kind = buf_bytes[pos];
        if (!((kind > 0 && kind < TYPE_LIMIT) || kind == STRING_FLAG)) return 0;
        len  = buf_bytes[pos + 1];
        size = HEADER_BYTES + len;
        if (rem < size) return 0;
        rec.record_tag    = (len > NUMERIC_MAX_LEN) ? (kind | STRING_FLAG) : kind;
        rec.record_length = len;
        rec.record_valid  = 1'b1;
        if (rec.record_tag[7]) begin
            // A zero-length string has the length byte itself as its last byte.
            last = (len == 0) ? pos + 1 : pos + 1 + len;
            if (!(buf_bytes[pos + 2] >= PRINT_LOW && buf_bytes[pos + 2] <= PRINT_HIGH
                  && buf_bytes[last] == 8'h00)) return 0;
            rec.string_offset = 9'(pos + 2);
        end else begin
            value = '0;
            for (int i = 0; i < len; i++) begin
                value |= 32'(buf_bytes[pos + 2 + i]) << (8 * i);
            end
            rec.numeric_value = value;
        end
        return size;
    endfunction

    task note_input(t_in_item item);
        int unsigned pos;
        int unsigned found;
        int unsigned size;
        int unsigned lim;
        bit          have_prev;
        t_out_item   rec;
        t_out_item   prev;
        if (fill < BUFFER_BYTES_DEF) begin
            buf_bytes[fill] = item.data_byte;
            fill++;
        end
        if (!item.end_of_buffer) return;
        lim       = (rec_limit > MAX_RECORDS_DEF) ? MAX_RECORDS_DEF : rec_limit;
        pos       = 0;
        found     = 0;
        have_prev = 1'b0;
        prev      = '0;
        while (pos < fill && found < lim) begin
            size = try_record(pos, rec);
            if (size > 0) begin
                if (have_prev) expected.push_back(prev);
                prev      = rec;
                have_prev = 1'b1;
                pos      += size;
                found++;
            end else begin
                pos++;
            end
        end
        // The final record of the scan carries the last mark; an empty scan
        // still gives one result.
        prev.last_record = 1'b1;
        expected.push_back(prev);
        fill = 0;
    endtask

    task check_result(t_out_item got);
        t_out_item want;
        if (expected.size() == 0) begin
            report($sformatf("record %h with nothing pending", got));
            return;
        end
        want = expected.pop_front();
        if (got.record_tag !== want.record_tag)
            report($sformatf("record_tag %h, want %h", got.record_tag, want.record_tag));
        if (got.record_length !== want.record_length)
            report($sformatf("record_length %h, want %h",
                             got.record_length, want.record_length));
        if (got.numeric_value !== want.numeric_value)
            report($sformatf("numeric_value %h, want %h",
                             got.numeric_value, want.numeric_value));
        if (got.string_offset !== want.string_offset)
            report($sformatf("string_offset %0d, want %0d",
                             got.string_offset, want.string_offset));
        if (got.record_valid !== want.record_valid)
            report($sformatf("record_valid %b, want %b", got.record_valid, want.record_valid));
        if (got.last_record !== want.last_record)
            report($sformatf("last_record %b, want %b", got.last_record, want.last_record));
    endtask
endclass

module tlv_record_scanner_unit_tb;

    // Run length guard, pauses and the size of each random phase.
    localparam int unsigned CYCLE_LIMIT   = 400000;
    localparam int unsigned SETTLE_CYCLES = 16;
    localparam int unsigned END_CYCLES    = 40;
    localparam int unsigned PHASE_COUNT   = 8;
    localparam int unsigned PHASE_ITEMS   = 45;
    localparam int unsigned BIG_PHASE     = 5;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_e;

    // All block inputs hold known values from time zero.
    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       in_valid    = 1'b0;
    t_in_item   in_data     = '0;
    logic       out_stall   = 1'b0;
    logic       cfg_wr_en   = 1'b0;
    logic [5:0] cfg_wr_data = '0;
    logic       o_stall;
    logic       o_valid;
    t_out_item  o_data;

    // Chances, in percent, that the sender idles or the receiver stalls in a cycle.
    int unsigned send_idle_pct = 0;
    int unsigned stall_pct     = 0;

    // Bytes of the buffer being built, sent in order with the last one final.
    logic [7:0] byte_q [$];
    int unsigned phase_items;

    tlv_scoreboard sb = new();

    tlv_record_scanner_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (in_valid),
        .o_stall       (o_stall),
        .i_data        (in_data),
        .o_valid       (o_valid),
        .i_stall       (out_stall),
        .o_data        (o_data),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Result side: a transfer happens at an edge where o_valid is high and our
    // stall is low, both seen as they stood before the edge. The stall for the
    // next cycle is drawn once per edge, so it gets one assignment per step.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !out_stall) sb.check_result(o_data);
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    // The watchdog counts cycles and ends a run that never drains.
    initial begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("tlv_record_scanner_unit regression: fail");
        $finish;
    end

    task automatic set_idling(input idle_mode_e mode);
        case (mode)
            IDLE_NONE: begin
                send_idle_pct = 0;
                stall_pct     = 0;
            end
            IDLE_SENDER: begin
                send_idle_pct = 53;
                stall_pct     = 0;
            end
            IDLE_RECEIVER: begin
                send_idle_pct = 0;
                stall_pct     = 53;
            end
            default: begin
                send_idle_pct = 14;
                stall_pct     = 14;
            end
        endcase
    endtask

    // Offers one byte and returns at the edge where the transfer took place.
    // Valid is left high so that a following byte without a gap goes out
    // back to back; a gap lowers it in a later step, never in the same one.
    task automatic send_item(input t_in_item item);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_input(item);
    endtask

    task automatic send_buffer();
        t_in_item item;
        for (int k = 0; k < byte_q.size(); k++) begin
            item.data_byte     = byte_q[k];
            item.end_of_buffer = (k == byte_q.size() - 1);
            send_item(item);
        end
        phase_items += byte_q.size();
        byte_q.delete();
    endtask

    // Lowers valid, lets every pending record come out, then waits longer so
    // that the block can close its scan before a register write.
    task automatic drain_and_settle(input int unsigned extra);
        in_valid <= 1'b0;
        while (sb.pending_count() != 0) @(posedge i_clk);
        repeat (extra) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [5:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge i_clk);
        cfg_wr_en   <= 1'b0;
        sb.set_limit(value);
    endtask

    task automatic add_noise(input int unsigned count);
        repeat (count) byte_q.push_back(8'($urandom_range(255)));
    endtask

    task automatic add_numeric();
        int unsigned len;
        len = $urandom_range(0, NUMERIC_MAX_LEN);
        byte_q.push_back(8'($urandom_range(1, TYPE_LIMIT - 1)));
        byte_q.push_back(8'(len));
        add_noise(len);
    endtask

    // A string either of type 0x80 or a numeric type with a long length. An
    // intact one has a printable first byte and, if it is longer than one byte, a
    // zero last byte; a broken one has random bytes in both places.
    task automatic add_string(input bit intact, input int unsigned max_len);
        logic [7:0]  kind;
        int unsigned len;
        kind = $urandom_range(1) ? STRING_FLAG : 8'($urandom_range(1, TYPE_LIMIT - 1));
        len  = (kind == STRING_FLAG) ? $urandom_range(0, max_len)
                                     : $urandom_range(NUMERIC_MAX_LEN + 1, max_len);
        byte_q.push_back(kind);
        byte_q.push_back(8'(len));
        if (len == 0) begin
            // The byte after a zero-length string alone decides whether it is kept.
            byte_q.push_back(intact ? 8'($urandom_range(PRINT_LOW, PRINT_HIGH))
                                    : 8'($urandom_range(255)));
        end else begin
            byte_q.push_back(intact ? 8'($urandom_range(PRINT_LOW, PRINT_HIGH))
                                    : 8'($urandom_range(255)));
            if (len > 1) begin
                add_noise(len - 2);
                byte_q.push_back(intact ? 8'h00 : 8'($urandom_range(255)));
            end
        end
    endtask

    // A header whose length runs past the end of the buffer.
    task automatic add_truncated();
        int unsigned len;
        len = $urandom_range(1, 20);
        byte_q.push_back($urandom_range(1) ? STRING_FLAG
                                           : 8'($urandom_range(1, TYPE_LIMIT - 1)));
        byte_q.push_back(8'(len));
        add_noise($urandom_range(0, len - 1));
    endtask

    task automatic add_record();
        case ($urandom_range(9))
            0, 1, 2, 3: add_numeric();
            4, 5, 6:    add_string(1'b1, 12);
            7:          add_string(1'b0, 12);
            8:          add_noise($urandom_range(1, 3));
            default:    add_string($urandom_range(1), 0);
        endcase
    endtask

    // Most buffers are runs of records with random content; the rest are
    // noise or end in a record cut short.
    task automatic build_random_buffer();
        int unsigned shape;
        shape = $urandom_range(99);
        if (shape < 10) begin
            add_noise($urandom_range(1, 12));
        end else begin
            repeat ($urandom_range(1, 6)) add_record();
            if (shape < 22) add_truncated();
        end
    endtask

    // A buffer longer than the store: long strings first so that the string
    // offsets reach high, then short records, then bytes that are dropped.
    task automatic build_big_buffer();
        byte_q.push_back(STRING_FLAG);
        byte_q.push_back(8'hFF);
        byte_q.push_back(8'h7E);
        add_noise(253);
        byte_q.push_back(8'h00);
        byte_q.push_back(8'h03);
        byte_q.push_back(8'd200);
        byte_q.push_back(8'h20);
        add_noise(198);
        byte_q.push_back(8'h00);
        while (byte_q.size() < BUFFER_BYTES_DEF + 20) add_record();
    endtask

    initial begin : stimulus
        logic [5:0] lim;
        phase_items = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, with the limit written to its reset value.
        write_limit(LIMIT_RESET);
        set_idling(IDLE_NONE);
        // An empty scan from a single zero byte, then from a single 0xFF byte.
        byte_q = '{8'h00};
        send_buffer();
        byte_q = '{8'hFF};
        send_buffer();
        // Widest numeric record, type 9 with no bytes, a zero-length string
        // kept by its printable follower, one rejected by an unprintable
        // follower, and a numeric type turned string by its length.
        byte_q = '{8'h01, 8'h04, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                   8'h09, 8'h00,
                   8'h80, 8'h00, 8'h41,
                   8'h80, 8'h00, 8'h1F,
                   8'h02, 8'h05, 8'h48, 8'h65, 8'h6C, 8'h6C, 8'h00};
        send_buffer();

        // Random phases, each with its own limit and idling pattern.
        for (int ph = 0; ph < PHASE_COUNT; ph++) begin
            case (ph)
                0:       lim = 6'd1;
                1:       lim = 6'd63;
                2:       lim = 6'd0;
                3:       lim = 6'd2;
                5:       lim = 6'd40;
                6:       lim = 6'd5;
                default: lim = 6'($urandom_range(1, MAX_RECORDS_DEF));
            endcase
            drain_and_settle(SETTLE_CYCLES);
            set_idling(idle_mode_e'(ph % 4));
            write_limit(lim);
            phase_items = 0;
            if (ph == BIG_PHASE) begin
                build_big_buffer();
                send_buffer();
                phase_items = 0;
            end
            while (phase_items < PHASE_ITEMS) begin
                build_random_buffer();
                send_buffer();
            end
        end

        drain_and_settle(END_CYCLES);
        if (sb.errors == 0) begin
            $display("tlv_record_scanner_unit regression: pass");
        end else begin
            $display("tlv_record_scanner_unit regression: fail");
        end
        $finish;
    end

endmodule
